>>> src/rcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

    localparam int FRAME_BYTES  = 16;
    localparam int NUM_CHANNELS = 7;
    localparam int MAP_ENTRIES  = 7;

    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int NPAIRS = (FRAME_BYTES - 2) / 2;
    localparam int PAIR_W = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DATA_W = 11;

    localparam logic [11:0] VALUE_BASE = 12'd988;

    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HIRES_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_RC      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_US      = 2'd3;

    localparam logic CMD_RECV = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECV,
        ST_UNPACK,
        ST_DRAIN,
        ST_LOOKUP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              latch_in;
        logic              do_recv;
        logic              rd_issue;
        logic [PAIR_W-1:0] rd_idx;
        logic              unpack_end;
        logic              do_lookup;
        logic              load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_pending;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> src/rcfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rcfd_pkg::dp_cmd_t      cmd,
    input  wire rcfd_pkg::dp_sts_t sts
);

    rcfd_pkg::state_t           state_reg, state_next;
    logic [rcfd_pkg::PAIR_W-1:0] pair_cnt_reg, pair_cnt_next;
    logic                        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rcfd_pkg::ST_IDLE;
            pair_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pair_cnt_reg  <= pair_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        pair_cnt_next  = pair_cnt_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.rd_idx     = pair_cnt_reg;

        // output register drains on its own
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rcfd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    if (in_cmd == rcfd_pkg::CMD_READ) begin
                        state_next = sts.frame_pending ? rcfd_pkg::ST_UNPACK
                                                       : rcfd_pkg::ST_LOOKUP;
                    end else begin
                        state_next = rcfd_pkg::ST_RECV;
                    end
                end
            end
            rcfd_pkg::ST_RECV: begin
                cmd.do_recv = 1'b1;
                state_next  = rcfd_pkg::ST_FIN;
            end
            rcfd_pkg::ST_UNPACK: begin
                cmd.rd_issue = 1'b1;
                if (pair_cnt_reg == rcfd_pkg::PAIR_W'(rcfd_pkg::NPAIRS - 1)) begin
                    pair_cnt_next = '0;
                    state_next    = rcfd_pkg::ST_DRAIN;
                end else begin
                    pair_cnt_next = pair_cnt_reg + 1'b1;
                end
            end
            rcfd_pkg::ST_DRAIN: begin
                // last slot pair lands in the store this cycle
                cmd.unpack_end = 1'b1;
                state_next     = rcfd_pkg::ST_LOOKUP;
            end
            rcfd_pkg::ST_LOOKUP: begin
                cmd.do_lookup = 1'b1;
                state_next    = rcfd_pkg::ST_FIN;
            end
            rcfd_pkg::ST_FIN: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rcfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/rcfd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfd_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rcfd_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic [7:0]                      in_byte,
    input  wire logic [31:0]                     in_time,
    input  wire logic [3:0]                      in_channel,
    input  wire rcfd_pkg::dp_cmd_t               cmd,
    output rcfd_pkg::dp_sts_t                    sts,
    output logic [11:0]                          out_value,
    output logic                                 out_done
);

    // configuration
    logic        hires_reg;
    logic [11:0] mid_rc_reg;
    logic [20:0] channel_map_reg;
    logic [19:0] gap_us_reg;

    // latched request
    logic [7:0]  byte_reg;
    logic [31:0] time_reg;
    logic [3:0]  channel_reg;

    // receive state
    logic [rcfd_pkg::POS_W-1:0]       pos_reg;
    logic [31:0]                      last_time_reg;
    logic                             pending_reg;
    logic                             seen_reg;
    logic [rcfd_pkg::FRAME_BYTES-1:0] slot_valid_reg;

    // frame buffer, two registered read ports
    logic [7:0] frame_mem [rcfd_pkg::FRAME_BYTES];
    logic [7:0] hi_q_reg, lo_q_reg;
    logic       hi_ok_reg, lo_ok_reg;
    logic       rd_valid_reg;

    logic [rcfd_pkg::DATA_W-1:0] store_reg [rcfd_pkg::NUM_CHANNELS];

    logic [11:0] res_value_reg;
    logic        res_done_reg;
    logic [11:0] out_value_reg;
    logic        out_done_reg;

    logic [31:0]                gap;
    logic                       gap_hit;
    logic [rcfd_pkg::POS_W-1:0] pos_eff;
    logic                       last_slot;
    logic [rcfd_pkg::POS_W-1:0] hi_addr, lo_addr;
    logic [7:0]                 hi_eff, lo_eff;
    logic [3:0]                 id;
    logic [rcfd_pkg::DATA_W-1:0] slot_data;
    logic [2:0]                 entry;
    logic                       hit;
    logic [rcfd_pkg::DATA_W-1:0] raw;
    logic [11:0]                value;

    always_comb begin
        gap       = time_reg - last_time_reg;
        gap_hit   = gap > {12'd0, gap_us_reg};
        pos_eff   = gap_hit ? '0 : pos_reg;
        last_slot = pos_eff == rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES - 1);

        hi_addr = rcfd_pkg::POS_W'(2 * int'(cmd.rd_idx) + 2);
        lo_addr = rcfd_pkg::POS_W'(2 * int'(cmd.rd_idx) + 3);
        hi_eff  = hi_ok_reg ? hi_q_reg : 8'd0;
        lo_eff  = lo_ok_reg ? lo_q_reg : 8'd0;
        if (hires_reg) begin
            id        = hi_eff[6:3];
            slot_data = {hi_eff[2:0], lo_eff};
        end else begin
            id        = hi_eff[5:2];
            slot_data = {1'b0, hi_eff[1:0], lo_eff};
        end

        entry = channel_map_reg[3 * int'(channel_reg[2:0]) +: 3];
        hit   = (channel_reg < 4'(rcfd_pkg::NUM_CHANNELS))
             && (channel_reg < 4'(rcfd_pkg::MAP_ENTRIES))
             && seen_reg
             && ({1'b0, entry} < 4'(rcfd_pkg::NUM_CHANNELS));
        raw   = store_reg[rcfd_pkg::CH_W'(entry)];
        if (hires_reg) begin
            raw = raw >> 1;
        end
        value = hit ? (rcfd_pkg::VALUE_BASE + 12'(raw)) : mid_rc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hires_reg       <= 1'b0;
            mid_rc_reg      <= 12'd1500;
            channel_map_reg <= 21'd1754760;
            gap_us_reg      <= 20'd5000;
        end else if (cfg_we) begin
            case (cfg_index)
                rcfd_pkg::REG_HIRES_MODE:  hires_reg       <= cfg_wdata[0];
                rcfd_pkg::REG_MID_RC:      mid_rc_reg      <= cfg_wdata[11:0];
                rcfd_pkg::REG_CHANNEL_MAP: channel_map_reg <= cfg_wdata[20:0];
                rcfd_pkg::REG_GAP_US:      gap_us_reg      <= cfg_wdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            byte_reg    <= in_byte;
            time_reg    <= in_time;
            channel_reg <= in_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            last_time_reg  <= '0;
            pending_reg    <= 1'b0;
            seen_reg       <= 1'b0;
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_issue;
            if (cmd.do_recv) begin
                seen_reg                <= 1'b1;
                last_time_reg           <= time_reg;
                slot_valid_reg[pos_eff] <= 1'b1;
                if (last_slot) begin
                    pending_reg <= 1'b1;
                    pos_reg     <= pos_eff;
                end else begin
                    pos_reg <= pos_eff + 1'b1;
                end
            end
            if (cmd.unpack_end) begin
                pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_recv) begin
            frame_mem[pos_eff] <= byte_reg;
        end
        if (cmd.rd_issue) begin
            hi_q_reg  <= frame_mem[hi_addr];
            lo_q_reg  <= frame_mem[lo_addr];
            hi_ok_reg <= slot_valid_reg[hi_addr];
            lo_ok_reg <= slot_valid_reg[lo_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rcfd_pkg::NUM_CHANNELS; i++) begin
                store_reg[i] <= '0;
            end
        end else if (rd_valid_reg && (id < 4'(rcfd_pkg::NUM_CHANNELS))) begin
            store_reg[rcfd_pkg::CH_W'(id)] <= slot_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_recv) begin
            res_value_reg <= '0;
            res_done_reg  <= last_slot;
        end else if (cmd.do_lookup) begin
            res_value_reg <= value;
            res_done_reg  <= 1'b0;
        end
        if (cmd.load_out) begin
            out_value_reg <= res_value_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign sts.frame_pending = pending_reg;
    assign out_value         = out_value_reg;
    assign out_done          = out_done_reg;

endmodule

`default_nettype wire

>>> src/satellite_rc_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    tuser command, tdata byte/time/channel
// m_axis    out        m_axis_tvalid/tready    tdata channel_value, tlast frame_done
// cfg       in         cfg_we (no back-pressure) cfg_index, cfg_wdata
//
// a receive request passes from accept to result through latch, buffer update and output load
// a read passes through latch, lookup and output load, with unpack and drain before the lookup
// if a full frame waits; unpack reads a slot pair per cycle via the frame buffer's two read ports
// one request at a time; the next is taken while the previous result waits in the output register
// reset is synchronous, active low, and needs no clearing pass

module satellite_rc_frame_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [47:0]                     s_axis_tdata,  // byte_value, time_us, channel
    input  wire logic                            s_axis_tuser,  // command
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // channel_value
    output logic                                 m_axis_tlast,  // frame_done
    input  wire logic                            cfg_we,
    input  wire logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rcfd_pkg::CFG_W-1:0]      cfg_wdata
);

    rcfd_pkg::dp_cmd_t cmd;
    rcfd_pkg::dp_sts_t sts;
    logic [11:0]       out_value;

    rcfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rcfd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_byte    (s_axis_tdata[7:0]),
        .in_time    (s_axis_tdata[39:8]),
        .in_channel (s_axis_tdata[43:40]),
        .cmd        (cmd),
        .sts        (sts),
        .out_value  (out_value),
        .out_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_value};

endmodule

`default_nettype wire
